@@ rtl/ectd_pkg.sv @@
// ectd_pkg: shared types and constants for the epoch-seconds-to-date converter.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ectd_pkg;

   // epoch day count fits in 16 bits (max 49710)
   localparam int unsigned EpochWidth = 32;
   localparam int unsigned DaysWidth  = 16;

   // reciprocal divider: quotient step, then remainder step
   localparam int unsigned DivCntWidth = 1;
   localparam logic [DivCntWidth-1:0] DIV_LAST = 1'd1;

   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
   localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
   localparam logic [5:0] HOURS_PER_DAY      = 6'd24;

   localparam logic [7:0] EPOCH_YEAR_OFS = 8'd70;   // 1970 - 1900
   localparam logic [3:0] LAST_MONTH     = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SEC,
      ST_DIV_MIN,
      ST_DIV_HOUR,
      ST_YEARS,
      ST_MONTHS,
      ST_FINISH
   } ctrl_state_type;

   // which field takes the divider remainder at the end of a pass
   typedef enum logic [1:0] {
      FLD_SEC,
      FLD_MIN,
      FLD_HOUR
   } div_field_type;

   typedef struct packed {
      logic          load_input;
      logic          div_step;
      logic          div_last;
      div_field_type div_field;
      logic          year_step;
      logic          month_step;
      logic          load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic year_last;
      logic month_last;
   } dp_status_type;

endpackage : ectd_pkg

`default_nettype wire

@@ rtl/ectd_dp.sv @@
// ectd_dp: datapath of the converter - shared reciprocal-multiply divider, year
// and month subtractors, weekday fold and result register. Depends on ectd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ectd_dp
   import ectd_pkg::*;
(
   input  wire logic                  clock,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   input  wire logic [EpochWidth-1:0] req_epoch_seconds,
   output logic [5:0]                 rsp_second,
   output logic [5:0]                 rsp_minute,
   output logic [4:0]                 rsp_hour,
   output logic [7:0]                 rsp_years_since_1900,
   output logic [3:0]                 rsp_month,
   output logic [4:0]                 rsp_day_of_month,
   output logic [2:0]                 rsp_weekday,
   output logic [8:0]                 rsp_day_of_year
);

   localparam logic [7:0] YOFS_1900 = 8'd0;
   localparam logic [7:0] YOFS_2100 = 8'd200;

   // x/60 = (x>>2)/15 and x/24 = (x>>3)/3, each by a reciprocal multiply
   localparam logic [31:0] RECIP_15 = 32'h8888_8889;   // ceil(2^35 / 15)
   localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;   // ceil(2^33 / 3)

   // Gregorian rule on 1900 + y: 1900 and 2100 are the only non-leap
   // multiples of four in the 8-bit offset range; 2000 is leap.
   function automatic logic is_leap(input logic [7:0] y);
      is_leap = (y[1:0] == 2'd0) && (y != YOFS_1900) && (y != YOFS_2100);
   endfunction

   function automatic logic [8:0] year_len(input logic [7:0] y);
      year_len = is_leap(y) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1:                    len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      month_len = len;
   endfunction

   // x mod 7 by folding octal digits (8 = 1 mod 7)
   function automatic logic [2:0] mod7(input logic [16:0] x);
      logic [5:0] s1;
      logic [3:0] s2;
      s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
         + {3'd0, x[14:12]} + {4'd0, x[16:15]};
      s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
      mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
   endfunction

   // ---------------- divider ----------------
   // first step of a pass registers the quotient, second step takes the
   // remainder from its low bits (remainder < 64, so 6-bit math suffices)
   logic [EpochWidth-1:0] div_num_ff;   // dividend of the current pass
   logic [EpochWidth-1:0] div_quo_ff;   // quotient of the current pass
   logic [5:0]            divisor;
   logic [31:0]           mul_a, mul_b;
   logic [63:0]           mul_p;
   logic [EpochWidth-1:0] div_quo_in;
   logic [11:0]           quo_x_div;
   logic [5:0]            div_rem;

   always_comb begin
      divisor    = (cmd.div_field == FLD_HOUR) ? HOURS_PER_DAY : SECONDS_PER_MINUTE;
      mul_a      = (cmd.div_field == FLD_HOUR) ? {3'd0, div_num_ff[EpochWidth-1:3]}
                                               : {2'd0, div_num_ff[EpochWidth-1:2]};
      mul_b      = (cmd.div_field == FLD_HOUR) ? RECIP_3 : RECIP_15;
      mul_p      = 64'(mul_a) * 64'(mul_b);
      div_quo_in = (cmd.div_field == FLD_HOUR) ? {1'b0, mul_p[63:33]}
                                               : {3'd0, mul_p[63:35]};
      quo_x_div  = {6'd0, div_quo_ff[5:0]} * {6'd0, divisor};
      div_rem    = 6'(div_num_ff[5:0] - quo_x_div[5:0]);
   end

   // ---------------- calendar ----------------
   logic [DaysWidth-1:0] day_rem_ff;
   logic [7:0]           yoff_ff;
   logic [8:0]           yday_ff;
   logic [3:0]           mon_ff;
   logic [5:0]           sec_ff;
   logic [5:0]           min_ff;
   logic [4:0]           hour_ff;
   logic [2:0]           wday_ff;

   logic [8:0]           len0, len1;
   logic [9:0]           len01;
   logic                 take1, take2;
   logic [DaysWidth-1:0] rem_sub0, rem_sub01, rem_subm;
   logic [4:0]           mlen;
   logic [16:0]          days_ofs;

   always_comb begin
      len0      = year_len(yoff_ff);
      len1      = year_len(8'(yoff_ff + 8'd1));
      len01     = {1'b0, len0} + {1'b0, len1};
      take2     = day_rem_ff >= {6'd0, len01};
      take1     = day_rem_ff >= {7'd0, len0};
      rem_sub0  = day_rem_ff - {7'd0, len0};
      rem_sub01 = day_rem_ff - {6'd0, len01};
      mlen      = month_len(mon_ff, is_leap(yoff_ff));
      rem_subm  = day_rem_ff - {11'd0, mlen};
      days_ofs  = {1'b0, div_quo_ff[DaysWidth-1:0]} + 17'd4;   // epoch day is Thursday

      status.year_last  = !take2;
      status.month_last = (mon_ff == LAST_MONTH) || (day_rem_ff < {11'd0, mlen});
   end

   always_ff @(posedge clock) begin
      if (cmd.load_input) begin
         div_num_ff <= req_epoch_seconds;
      end else if (cmd.div_step) begin
         if (!cmd.div_last) begin
            div_quo_ff <= div_quo_in;
         end else begin
            div_num_ff <= div_quo_ff;
            case (cmd.div_field)
               FLD_SEC: sec_ff <= div_rem;
               FLD_MIN: min_ff <= div_rem;
               FLD_HOUR: begin
                  hour_ff    <= div_rem[4:0];
                  day_rem_ff <= div_quo_ff[DaysWidth-1:0];
                  yoff_ff    <= EPOCH_YEAR_OFS;
                  wday_ff    <= mod7(days_ofs);
               end
               default: ;
            endcase
         end
      end

      if (cmd.year_step) begin
         if (take2) begin
            day_rem_ff <= rem_sub01;
            yoff_ff    <= 8'(yoff_ff + 8'd2);
         end else begin
            mon_ff <= '0;
            if (take1) begin
               day_rem_ff <= rem_sub0;
               yoff_ff    <= 8'(yoff_ff + 8'd1);
               yday_ff    <= rem_sub0[8:0];
            end else begin
               yday_ff <= day_rem_ff[8:0];
            end
         end
      end

      if (cmd.month_step && !status.month_last) begin
         day_rem_ff <= rem_subm;
         mon_ff     <= 4'(mon_ff + 4'd1);
      end

      if (cmd.load_rsp) begin
         rsp_second           <= sec_ff;
         rsp_minute           <= min_ff;
         rsp_hour             <= hour_ff;
         rsp_years_since_1900 <= yoff_ff;
         rsp_month            <= mon_ff;
         rsp_day_of_month     <= 5'(day_rem_ff[4:0] + 5'd1);
         rsp_weekday          <= wday_ff;
         rsp_day_of_year      <= yday_ff;
      end
   end

endmodule : ectd_dp

`default_nettype wire

@@ rtl/ectd_ctrl.sv @@
// ectd_ctrl: sequencing state machine and result-valid flag of the converter.
// Depends on ectd_pkg; drives the ectd_dp command struct.
`timescale 1ns / 1ps
`default_nettype none

module ectd_ctrl
   import ectd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   ctrl_state_type         state_ff, state_in;
   logic [DivCntWidth-1:0] cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   can_load;
   logic                   cnt_end;

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign cnt_end   = (cnt_ff == DIV_LAST);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DIV_SEC;
         ST_DIV_SEC:  if (cnt_end) state_in = ST_DIV_MIN;
         ST_DIV_MIN:  if (cnt_end) state_in = ST_DIV_HOUR;
         ST_DIV_HOUR: if (cnt_end) state_in = ST_YEARS;
         ST_YEARS:    if (status.year_last) state_in = ST_MONTHS;
         ST_MONTHS:   if (status.month_last) state_in = ST_FINISH;
         ST_FINISH:   if (can_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.div_field = FLD_SEC;
      cnt_in    = '0;
      unique case (state_ff)
         ST_IDLE: cmd.load_input = req_valid;
         ST_DIV_SEC, ST_DIV_MIN, ST_DIV_HOUR: begin
            cmd.div_step = 1'b1;
            cmd.div_last = cnt_end;
            cnt_in       = DivCntWidth'(cnt_ff + 1'b1);
            if (state_ff == ST_DIV_MIN)  cmd.div_field = FLD_MIN;
            if (state_ff == ST_DIV_HOUR) cmd.div_field = FLD_HOUR;
         end
         ST_YEARS:  cmd.year_step  = 1'b1;
         ST_MONTHS: cmd.month_step = 1'b1;
         ST_FINISH: cmd.load_rsp   = can_load;
         default: ;
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule : ectd_ctrl

`default_nettype wire

@@ rtl/epoch_seconds_to_calendar_date.sv @@
// epoch_seconds_to_calendar_date: top level, Unix seconds to UTC calendar date.
// Depends on ectd_pkg, ectd_ctrl and ectd_dp.
//
// Takes an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC on the
// req_ channel and returns one rsp_ transaction with the UTC breakdown: second,
// minute, hour, years since 1900, month (0 = January), day of month (from 1),
// weekday (0 = Sunday) and day of year (0 = January 1), Gregorian leap rules on
// the full year. One transaction is in work at a time; req_stall is high from
// acceptance until the result is loaded into the output register. A finished
// result waits there while the next transaction is accepted and processed.
// From acceptance to rsp_valid the work runs through a shared reciprocal-multiply
// divider in three passes (by 60, by 60, by 24), each a quotient step and a
// remainder step, then the year loop, which retires up to two years per cycle,
// then the month loop, one month per cycle, and last the load of the output
// register. The next transaction can be accepted in the cycle after that load;
// while the output register still holds an unaccepted result, that load waits.
// The year and month loops are what make latency depend on the date. No reset
// sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_date
   import ectd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [EpochWidth-1:0] req_epoch_seconds,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [5:0]                 rsp_second,
   output logic [5:0]                 rsp_minute,
   output logic [4:0]                 rsp_hour,
   output logic [7:0]                 rsp_years_since_1900,
   output logic [3:0]                 rsp_month,
   output logic [4:0]                 rsp_day_of_month,
   output logic [2:0]                 rsp_weekday,
   output logic [8:0]                 rsp_day_of_year
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller: sequences divider passes, year and month loops, result load
   ectd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: all arithmetic and the output register
   ectd_dp u_dp (
      .clock                (clock),
      .cmd                  (cmd),
      .status               (status),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_second           (rsp_second),
      .rsp_minute           (rsp_minute),
      .rsp_hour             (rsp_hour),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_month            (rsp_month),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_year      (rsp_day_of_year)
   );

endmodule : epoch_seconds_to_calendar_date

`default_nettype wire

@@ rtl/ectd_checker.sv @@
// ectd_checker: port-level assertions for epoch_seconds_to_calendar_date,
// bound to the top level. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ectd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [5:0]  rsp_second,
   input wire logic [5:0]  rsp_minute,
   input wire logic [4:0]  rsp_hour,
   input wire logic [7:0]  rsp_years_since_1900,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day_of_month,
   input wire logic [2:0]  rsp_weekday,
   input wire logic [8:0]  rsp_day_of_year
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_second) && $stable(rsp_minute)
         && $stable(rsp_hour) && $stable(rsp_years_since_1900) && $stable(rsp_month)
         && $stable(rsp_day_of_month) && $stable(rsp_weekday) && $stable(rsp_day_of_year))
      else $error("stalled response changed");

   // one transaction at a time: busy right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // a new result only appears at the end of work on a request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without request in work");

   // time-of-day and date fields stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_second < 6'd60 && rsp_minute < 6'd60 && rsp_hour < 5'd24
         && rsp_month < 4'd12 && rsp_day_of_month != 5'd0 && rsp_weekday < 3'd7
         && rsp_day_of_year < 9'd366 && rsp_years_since_1900 >= 8'd70
         && rsp_years_since_1900 <= 8'd206)
      else $error("response field out of range");

endmodule : ectd_checker

bind epoch_seconds_to_calendar_date ectd_checker u_ectd_checker (.*);

`default_nettype wire
